FILE: src/pol_pkg.sv
// Package for the positional ordered list: codes, defaults and transfer types.
`default_nettype none
package pol_pkg;

  localparam int unsigned CapacityDefault  = 32;
  localparam int unsigned DataWidthDefault = 32;

  // operation codes
  localparam logic [2:0] OP_APPEND     = 3'd0;
  localparam logic [2:0] OP_INSERT     = 3'd1;
  localparam logic [2:0] OP_DEL_FIRST  = 3'd2;
  localparam logic [2:0] OP_DEL_AFTER  = 3'd3;
  localparam logic [2:0] OP_READ_ALL   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BOUNDS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic [7:0]         position;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               last;
  } rsp_t;

endpackage
`default_nettype wire

FILE: src/positional_ordered_list_unit.sv
// Top level of the positional ordered list: sequencer, element memory and result register.
`default_nettype none
// Keeps an ordered list of up to CAPACITY signed words in a single-port element memory
// with a registered read. A command transfers at a rising edge with start_i high and
// busy_o low; busy_o stays high until the command's memory walk is done. Each result
// is presented on rsp_o for exactly one cycle with rsp_valid_o high and must be taken
// then: the receiver cannot stall the block. Timing is set by the memory port, which
// does one read or one write per cycle, so every element moved needs a read and a write:
//   append, rejected commands, unknown codes: answered from idle, busy_o never rises.
//   insert before position p: elements from p on move up a slot, then the value is written.
//   delete first, delete after p: the elements behind the removed one move down a slot.
//   read all: one result per element, read then output, last on the final one.
// Results are registered and appear in the cycle after the one that completes them. Reading
// all from an empty list answers with a single empty status. No clearing pass runs after
// reset: only the first length slots are ever read.
module positional_ordered_list_unit #(
  parameter int unsigned CAPACITY   = pol_pkg::CapacityDefault,
  parameter int unsigned DATA_WIDTH = pol_pkg::DataWidthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  pol_pkg::cmd_t      cmd_i,
  output logic               busy_o,
  output logic               rsp_valid_o,
  output pol_pkg::rsp_t      rsp_o
);

  localparam int unsigned LenW  = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_RD_ISSUE,
    S_RD_OUT
  } state_e;

  state_e                       state_q;
  logic [LenW-1:0]              length_q;
  logic [AddrW-1:0]             idx_q;
  logic [AddrW-1:0]             tgt_q;
  logic signed [DATA_WIDTH-1:0] val_q;
  logic                         rsp_valid_q;
  pol_pkg::rsp_t                rsp_q;

  // element memory
  logic signed [DATA_WIDTH-1:0] mem_q [CAPACITY];
  logic signed [DATA_WIDTH-1:0] rd_q;
  logic                         mem_we, mem_re;
  logic [AddrW-1:0]             mem_wa, mem_ra;
  logic signed [DATA_WIDTH-1:0] mem_wd;

  logic                         accept;
  logic                         full;
  logic                         empty;
  logic [8:0]                   pos9;
  logic [8:0]                   len9;
  logic                         ins_oob;
  logic                         del_oob;
  logic signed [DATA_WIDTH-1:0] val_store;
  logic                         del_done;
  logic                         rd_last;

  assign accept    = start_i && (state_q == S_IDLE);
  assign full      = (length_q == LenW'(CAPACITY));
  assign empty     = (length_q == '0);
  assign pos9      = {1'b0, cmd_i.position};
  assign len9      = 9'(length_q);
  assign ins_oob   = (cmd_i.position == 8'd0) || (pos9 > len9 + 9'd1);
  assign del_oob   = (cmd_i.position == 8'd0) || (pos9 + 9'd1 > len9);
  assign val_store = DATA_WIDTH'(cmd_i.value);
  // the shift-down walk ends when the cursor reaches the tail slot
  assign del_done  = (LenW'(idx_q) + LenW'(1) >= length_q);
  assign rd_last   = (LenW'(idx_q) + LenW'(1) == length_q);

  // Steer the single memory port from the sequencer state.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_q;
    mem_wd = rd_q;
    mem_re = 1'b0;
    mem_ra = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (cmd_i.operation == pol_pkg::OP_APPEND) && !full) begin
          mem_we = 1'b1;
          mem_wa = length_q[AddrW-1:0];
          mem_wd = val_store;
        end
      end
      S_INS_RD: begin
        if (idx_q == tgt_q) begin
          mem_we = 1'b1;
          mem_wd = val_q;
        end else begin
          mem_re = 1'b1;
          mem_ra = idx_q - AddrW'(1);
        end
      end
      S_INS_WR: mem_we = 1'b1;
      S_DEL_RD: begin
        if (!del_done) begin
          mem_re = 1'b1;
          mem_ra = idx_q + AddrW'(1);
        end
      end
      S_DEL_WR:   mem_we = 1'b1;
      S_RD_ISSUE: mem_re = 1'b1;
      S_RD_OUT:   ;
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_ra];
    end
  end

  // Sequencer, list length and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      length_q    <= '0;
      idx_q       <= '0;
      tgt_q       <= '0;
      val_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      rsp_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            // default answer: single result, element zero
            rsp_q.status  <= pol_pkg::ST_OK;
            rsp_q.element <= '0;
            rsp_q.last    <= 1'b1;
            unique case (cmd_i.operation)
              pol_pkg::OP_APPEND: begin
                rsp_valid_q <= 1'b1;
                if (full) begin
                  rsp_q.status <= pol_pkg::ST_FULL;
                end else begin
                  length_q <= length_q + LenW'(1);
                end
              end
              pol_pkg::OP_INSERT: begin
                if (empty) begin
                  rsp_valid_q  <= 1'b1;
                  rsp_q.status <= pol_pkg::ST_EMPTY;
                end else if (ins_oob) begin
                  rsp_valid_q  <= 1'b1;
                  rsp_q.status <= pol_pkg::ST_BOUNDS;
                end else if (full) begin
                  rsp_valid_q  <= 1'b1;
                  rsp_q.status <= pol_pkg::ST_FULL;
                end else begin
                  // walk down from the tail, opening a slot at position-1
                  idx_q   <= length_q[AddrW-1:0];
                  tgt_q   <= AddrW'(cmd_i.position - 8'd1);
                  val_q   <= val_store;
                  state_q <= S_INS_RD;
                end
              end
              pol_pkg::OP_DEL_FIRST: begin
                if (empty) begin
                  rsp_valid_q  <= 1'b1;
                  rsp_q.status <= pol_pkg::ST_EMPTY;
                end else begin
                  idx_q   <= '0;
                  state_q <= S_DEL_RD;
                end
              end
              pol_pkg::OP_DEL_AFTER: begin
                if (empty) begin
                  rsp_valid_q  <= 1'b1;
                  rsp_q.status <= pol_pkg::ST_EMPTY;
                end else if (del_oob) begin
                  rsp_valid_q  <= 1'b1;
                  rsp_q.status <= pol_pkg::ST_BOUNDS;
                end else begin
                  // the element after 1-based position p sits at index p
                  idx_q   <= AddrW'(cmd_i.position);
                  state_q <= S_DEL_RD;
                end
              end
              pol_pkg::OP_READ_ALL: begin
                if (empty) begin
                  rsp_valid_q  <= 1'b1;
                  rsp_q.status <= pol_pkg::ST_EMPTY;
                end else begin
                  idx_q   <= '0;
                  state_q <= S_RD_ISSUE;
                end
              end
              default: begin
                // unknown code: no effect, plain ok
                rsp_valid_q <= 1'b1;
              end
            endcase
          end
        end
        S_INS_RD: begin
          if (idx_q == tgt_q) begin
            length_q    <= length_q + LenW'(1);
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          idx_q   <= idx_q - AddrW'(1);
          state_q <= S_INS_RD;
        end
        S_DEL_RD: begin
          if (del_done) begin
            length_q    <= length_q - LenW'(1);
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_DEL_WR;
          end
        end
        S_DEL_WR: begin
          idx_q   <= idx_q + AddrW'(1);
          state_q <= S_DEL_RD;
        end
        S_RD_ISSUE: begin
          state_q <= S_RD_OUT;
        end
        S_RD_OUT: begin
          rsp_valid_q   <= 1'b1;
          rsp_q.status  <= pol_pkg::ST_OK;
          rsp_q.element <= 32'(rd_q);
          rsp_q.last    <= rd_last;
          idx_q         <= idx_q + AddrW'(1);
          state_q       <= rd_last ? S_IDLE : S_RD_ISSUE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
`default_nettype wire
